>>> design/dmwct_pkg.sv
`default_nettype none

package dmwct_pkg;

   // Field widths of the request and response items.
   localparam int unsigned MODE_W  = 2;
   localparam int unsigned BLOCK_W = 23;

   // Cache geometry: the line is the low part of the block number, the tag the rest.
   localparam int unsigned LINES   = 32768;
   localparam int unsigned IDX_W   = $clog2(LINES);
   localparam int unsigned TAG_W   = BLOCK_W - IDX_W;

   // Tag RAM word: valid, dirty, tag from the top bit down.
   localparam int unsigned ENTRY_W = TAG_W + 2;

   // Packed stream widths, rounded up to whole bytes.
   localparam int unsigned REQ_BITS = MODE_W + BLOCK_W;
   localparam int unsigned REQ_W    = ((REQ_BITS + 7) / 8) * 8;
   localparam int unsigned RSP_BITS = 1 + 1 + BLOCK_W + 1 + IDX_W;
   localparam int unsigned RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   typedef enum logic [MODE_W-1:0] {
      MODE_READ   = 2'd0,
      MODE_WRITE  = 2'd1,
      MODE_SYNC   = 2'd2,
      MODE_REMOVE = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOKUP
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic clear_en;   // write one zero entry at the clear pointer
      logic load;       // capture the request and read its line
      logic commit;     // update the line and load the response register
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic clear_last; // clear pointer is at the final line
      logic out_free;   // response register can take a new item this cycle
   } status_type;

endpackage

`default_nettype wire

>>> design/dmwct_ctrl.sv
`default_nettype none

module dmwct_ctrl
   import dmwct_pkg::*;
(
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  status_type  status,
   output cmd_type     cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_tready   = 1'b0;
      cmd.clear_en = 1'b0;
      cmd.load     = 1'b0;
      cmd.commit   = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_LOOKUP;
            end
         end
         ST_LOOKUP: begin
            // Hold the looked-up entry until the response register has room.
            if (status.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> design/dmwct_dp.sv
`default_nettype none

module dmwct_dp
   import dmwct_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   input  wire  [REQ_W-1:0]    req_tdata,
   input  cmd_type             cmd,
   output status_type          status,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   output logic [RSP_W-1:0]    rsp_tdata
);

   logic [ENTRY_W-1:0] tag_ram [LINES];

   logic [IDX_W-1:0]   clr_ff;
   logic [MODE_W-1:0]  mode_ff;
   logic [BLOCK_W-1:0] blk_ff;
   logic [ENTRY_W-1:0] rd_ff;

   logic               rsp_valid_ff;
   logic               hit_ff;
   logic               wb_ff;
   logic [BLOCK_W-1:0] wb_blk_ff;
   logic               fill_ff;
   logic [IDX_W-1:0]   idx_out_ff;

   logic [BLOCK_W-1:0] req_blk;
   logic [IDX_W-1:0]   req_idx;
   logic [IDX_W-1:0]   idx;
   logic [TAG_W-1:0]   tag;
   logic               ent_valid;
   logic               ent_dirty;
   logic [TAG_W-1:0]   ent_tag;
   logic               match;
   logic               hit_in;
   logic               wb_in;
   logic [BLOCK_W-1:0] wb_blk_in;
   logic               fill_in;
   logic [ENTRY_W-1:0] entry_in;

   assign req_blk   = req_tdata[MODE_W +: BLOCK_W];
   assign req_idx   = req_blk[IDX_W-1:0];
   assign idx       = blk_ff[IDX_W-1:0];
   assign tag       = blk_ff[BLOCK_W-1:IDX_W];
   assign ent_valid = rd_ff[ENTRY_W-1];
   assign ent_dirty = rd_ff[ENTRY_W-2];
   assign ent_tag   = rd_ff[TAG_W-1:0];
   assign match     = ent_valid && (ent_tag == tag);

   always_comb begin
      hit_in    = match;
      wb_in     = 1'b0;
      wb_blk_in = '0;
      fill_in   = 1'b0;
      entry_in  = rd_ff;
      unique case (mode_type'(mode_ff))
         MODE_READ, MODE_WRITE: begin
            if (!match) begin
               if (ent_valid && ent_dirty) begin
                  wb_in     = 1'b1;
                  wb_blk_in = {ent_tag, idx};
               end
               fill_in  = 1'b1;
               entry_in = {1'b1, 1'b0, tag};
            end
            if (mode_type'(mode_ff) == MODE_WRITE) begin
               entry_in[ENTRY_W-2] = 1'b1;
            end
         end
         MODE_SYNC: begin
            if (match && ent_dirty) begin
               wb_in               = 1'b1;
               wb_blk_in           = blk_ff;
               entry_in[ENTRY_W-2] = 1'b0;
            end
         end
         MODE_REMOVE: begin
            if (match) begin
               entry_in = '0;
            end
         end
         default: begin
            entry_in = rd_ff;
         end
      endcase
   end

   // Tag RAM: one write port shared by the clearing pass and the update, one read port.
   always_ff @(posedge clock) begin
      if (cmd.clear_en) begin
         tag_ram[clr_ff] <= '0;
      end else if (cmd.commit) begin
         tag_ram[idx] <= entry_in;
      end
      if (cmd.load) begin
         rd_ff <= tag_ram[req_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else if (cmd.clear_en) begin
         clr_ff <= clr_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         mode_ff <= req_tdata[MODE_W-1:0];
         blk_ff  <= req_blk;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.commit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         hit_ff     <= hit_in;
         wb_ff      <= wb_in;
         wb_blk_ff  <= wb_blk_in;
         fill_ff    <= fill_in;
         idx_out_ff <= idx;
      end
   end

   assign status.clear_last = (clr_ff == IDX_W'(LINES - 1));
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_W'({idx_out_ff, fill_ff, wb_blk_ff, wb_ff, hit_ff});

endmodule

`default_nettype wire

>>> design/direct_mapped_writeback_cache_tags.sv
`default_nettype none

// Tag and dirty-bit controller of a direct-mapped write-back block cache with 32768 lines.
// Each request item carries an operation (read, write, sync or remove) and a 23-bit disk
// block number; the low 15 bits select the line and the upper 8 bits form the tag. For
// every request the block returns exactly one response item that reports whether the line
// held the block, whether a dirty line has to be written to disk (and which block that is),
// whether the requested block has to be read into the line, and the line index. The block
// only issues these commands; the data copies and the disk transfers are done elsewhere.
// After reset the block sweeps the tag RAM to clear every valid and dirty bit, one line per
// cycle, and req_tready stays low until every line is clear. Each request after that is
// handled in two steps: its line is read from the tag RAM into a register, then the
// updated line is written back, and no request is taken in between. A finished response
// waits in an output register, and a further request is accepted meanwhile; only when a
// second response is ready and the first has still not been taken does the block hold off.
module direct_mapped_writeback_cache_tags
   import dmwct_pkg::*;
(
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_tvalid,
   output logic                req_tready,
   // [1:0] mode, [24:2] block_number, upper bits zero
   input  wire  [REQ_W-1:0]    req_tdata,
   output logic                rsp_tvalid,
   input  wire                 rsp_tready,
   // [0] hit, [1] writeback_needed, [24:2] writeback_block, [25] fill_needed,
   // [40:26] line_index, upper bits zero
   output logic [RSP_W-1:0]    rsp_tdata
);

   cmd_type    cmd;
   status_type status;

   // The controller sequences the clearing pass and the read-then-update of each request.
   dmwct_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // The datapath holds the tag RAM, the request registers and the response register.
   dmwct_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .cmd        (cmd),
      .status     (status),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // A request is followed by its update cycle, so no item can be taken straight after one.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("request accepted in the update cycle");

   // The clearing pass and the line update never drive the RAM write port together.
   a_write_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.clear_en && cmd.commit))
      else $error("clearing pass and update collide on the tag RAM");

   // A response without a writeback carries a zero writeback block.
   a_wb_block_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tdata[1]) |-> (rsp_tdata[24:2] == '0))
      else $error("writeback block set without writeback");

   // A fill is only ordered on a miss.
   a_fill_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[25]) |-> !rsp_tdata[0])
      else $error("fill ordered on a hit");

endmodule

`default_nettype wire

>>> tb/testbench.sv
`default_nettype none

// Testbench of the direct-mapped write-back cache tag controller.
//
// Request items carry an operation and a disk block number. Every accepted item is run
// through a shadow copy of the tag store kept here, which works out the one response item
// it must cause. That expectation joins a queue, and each response item taken from the
// block is compared field by field with the oldest entry in the queue.
//
// The stimulus opens with a short table of hand-picked items: both ends of the block
// number range, every operation, clean and dirty misses, a dirty victim whose block
// number is zero, syncs and removes of lines that hold another block, and the removal of
// a dirty line. Where the response can be read straight off the table, it is typed into
// the row. After the table come random items, mostly aimed at a small set of busy lines
// and a handful of tags so that hits, dirty victims and syncs happen often. The rest
// spread over the whole block number range.
module testbench
   import dmwct_pkg::*;
;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned HOT_LINES    = 16;
   localparam int unsigned HOT_W        = $clog2(HOT_LINES);
   localparam int unsigned PHASE_ITEMS  = 578;
   localparam int unsigned HOLD_AT_ITEM = 900;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned DRAIN_CYCLES = 16;

   // One response item, unpacked into its fields.
   typedef struct {
      logic             hit;
      logic             wb;
      logic [BLOCK_W-1:0] wb_blk;
      logic             fill;
      logic [IDX_W-1:0] idx;
   } rsp_fields_type;

   // One row of the directed table. When typed is set, the response fields of the row
   // are the expectation. Otherwise the shadow tag store supplies it.
   typedef struct {
      mode_type         op;
      logic [BLOCK_W-1:0] blk;
      bit               typed;
      logic             hit;
      logic             wb;
      logic [BLOCK_W-1:0] wb_blk;
      logic             fill;
      logic [IDX_W-1:0] idx;
   } dir_row_type;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;

   // Shadow copy of the tag store. Valid and dirty bits start cleared, as after reset.
   bit               shadow_valid [LINES];
   bit               shadow_dirty [LINES];
   logic [TAG_W-1:0] shadow_tag   [LINES];

   rsp_fields_type   pending_rsps [$];
   int unsigned      mismatches   = 0;
   int unsigned      reqs_taken   = 0;
   int unsigned      send_idle_pct = 37;
   int unsigned      recv_idle_pct = 51;

   // Block 8355839 sits on the last line with tag 254, one tag below 8388607.
   dir_row_type directed_rows [22] = '{
      '{MODE_READ,   23'd0,        1'b1, 1'b0, 1'b0, 23'd0,       1'b1, 15'd0},
      '{MODE_READ,   23'd0,        1'b1, 1'b1, 1'b0, 23'd0,       1'b0, 15'd0},
      '{MODE_WRITE,  23'd0,        1'b1, 1'b1, 1'b0, 23'd0,       1'b0, 15'd0},
      '{MODE_READ,   23'd8388607,  1'b1, 1'b0, 1'b0, 23'd0,       1'b1, 15'd32767},
      '{MODE_WRITE,  23'd32768,    1'b1, 1'b0, 1'b1, 23'd0,       1'b1, 15'd0},
      '{MODE_SYNC,   23'd32768,    1'b1, 1'b1, 1'b1, 23'd32768,   1'b0, 15'd0},
      '{MODE_SYNC,   23'd32768,    1'b1, 1'b1, 1'b0, 23'd0,       1'b0, 15'd0},
      '{MODE_SYNC,   23'd0,        1'b1, 1'b0, 1'b0, 23'd0,       1'b0, 15'd0},
      '{MODE_WRITE,  23'd8388607,  1'b1, 1'b1, 1'b0, 23'd0,       1'b0, 15'd32767},
      '{MODE_REMOVE, 23'd8355839,  1'b1, 1'b0, 1'b0, 23'd0,       1'b0, 15'd32767},
      '{MODE_REMOVE, 23'd8388607,  1'b1, 1'b1, 1'b0, 23'd0,       1'b0, 15'd32767},
      '{MODE_READ,   23'd8388607,  1'b1, 1'b0, 1'b0, 23'd0,       1'b1, 15'd32767},
      '{MODE_WRITE,  23'd8388607,  1'b1, 1'b1, 1'b0, 23'd0,       1'b0, 15'd32767},
      '{MODE_READ,   23'd32767,    1'b1, 1'b0, 1'b1, 23'd8388607, 1'b1, 15'd32767},
      '{MODE_REMOVE, 23'd12345,    1'b1, 1'b0, 1'b0, 23'd0,       1'b0, 15'd12345},
      '{MODE_SYNC,   23'h2AAAAA,   1'b1, 1'b0, 1'b0, 23'd0,       1'b0, 15'd10922},
      '{MODE_WRITE,  23'h2AAAAA,   1'b0, 1'b0, 1'b0, 23'd0,       1'b0, 15'd0},
      '{MODE_WRITE,  23'h555555,   1'b0, 1'b0, 1'b0, 23'd0,       1'b0, 15'd0},
      '{MODE_REMOVE, 23'h2AAAAA,   1'b0, 1'b0, 1'b0, 23'd0,       1'b0, 15'd0},
      '{MODE_READ,   23'h555555,   1'b0, 1'b0, 1'b0, 23'd0,       1'b0, 15'd0},
      '{MODE_SYNC,   23'h555555,   1'b0, 1'b0, 1'b0, 23'd0,       1'b0, 15'd0},
      '{MODE_READ,   23'h2AAAAA,   1'b0, 1'b0, 1'b0, 23'd0,       1'b0, 15'd0}
   };

   direct_mapped_writeback_cache_tags dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // Works out the response to one request and updates the shadow tag store. The line
   // count is a power of two, so the line is the low part of the block number and the
   // tag is the rest.
   function automatic rsp_fields_type cache_lookup(mode_type op, logic [BLOCK_W-1:0] blk);
      logic [IDX_W-1:0] idx;
      logic [TAG_W-1:0] tg;
      logic             match;
      rsp_fields_type   r;
      idx      = blk[IDX_W-1:0];
      tg       = blk[BLOCK_W-1:IDX_W];
      match    = shadow_valid[idx] && (shadow_tag[idx] == tg);
      r.hit    = match;
      r.wb     = 1'b0;
      r.wb_blk = '0;
      r.fill   = 1'b0;
      r.idx    = idx;
      unique case (op)
         MODE_READ, MODE_WRITE: begin
            if (!match) begin
               // A dirty victim goes back to disk under its own block number.
               if (shadow_valid[idx] && shadow_dirty[idx]) begin
                  r.wb     = 1'b1;
                  r.wb_blk = {shadow_tag[idx], idx};
               end
               shadow_dirty[idx] = 1'b0;
               shadow_tag[idx]   = tg;
               shadow_valid[idx] = 1'b1;
               r.fill            = 1'b1;
            end
            if (op == MODE_WRITE) begin
               shadow_dirty[idx] = 1'b1;
            end
         end
         MODE_SYNC: begin
            if (match && shadow_dirty[idx]) begin
               r.wb              = 1'b1;
               r.wb_blk          = blk;
               shadow_dirty[idx] = 1'b0;
            end
         end
         default: begin
            // Remove drops a matching line, dirty or not, without any writeback.
            if (match) begin
               shadow_dirty[idx] = 1'b0;
               shadow_valid[idx] = 1'b0;
            end
         end
      endcase
      return r;
   endfunction

   // Offers one request item, after a random gap, and holds it until the block takes it.
   // The expectation is queued at the edge where the item is accepted.
   task automatic offer(mode_type op, logic [BLOCK_W-1:0] blk, rsp_fields_type want);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= REQ_W'({blk, op});
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      pending_rsps.push_back(want);
      reqs_taken++;
   endtask

   function automatic void field_check(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
         mismatches++;
      end
   endfunction

   // Response side: checks every item taken and decides rsp_tready for the next edge.
   // Once, after a fixed number of requests, it holds off for a long stretch while the
   // sender keeps offering, so that the block backs up and stalls its input.
   initial begin : response_side
      rsp_fields_type want;
      int unsigned    hold_left;
      bit             held;
      hold_left = 0;
      held      = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset) begin
            if (rsp_tvalid && rsp_tready) begin
               if (pending_rsps.size() == 0) begin
                  $display("%0t: response item with no request outstanding, expected none, got %h",
                           $time, rsp_tdata);
                  mismatches++;
               end else begin
                  want = pending_rsps.pop_front();
                  field_check("hit",        32'(want.hit),    32'(rsp_tdata[0]));
                  field_check("writeback",  32'(want.wb),     32'(rsp_tdata[1]));
                  field_check("wb block",   32'(want.wb_blk), 32'(rsp_tdata[BLOCK_W+1:2]));
                  field_check("fill",       32'(want.fill),   32'(rsp_tdata[BLOCK_W+2]));
                  field_check("line index", 32'(want.idx),
                              32'(rsp_tdata[BLOCK_W+IDX_W+2:BLOCK_W+3]));
               end
            end
            if (!held && reqs_taken >= HOLD_AT_ITEM) begin
               held      = 1'b1;
               hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
               hold_left--;
               rsp_tready <= 1'b0;
            end else begin
               rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
         end
      end
   end

   // Guards against a hang. The limit covers the clearing sweep after reset plus many
   // times the slowest plausible pass through the stimulus.
   initial begin : watchdog
      int unsigned cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("[FAIL] regression broken");
      $finish;
   end

   initial begin : stimulus
      logic [IDX_W-1:0]   hot [HOT_LINES];
      logic [IDX_W-1:0]   idx;
      logic [TAG_W-1:0]   tg;
      logic [BLOCK_W-1:0] blk;
      mode_type           op;
      rsp_fields_type     want;
      int unsigned        pick;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed table. Typed rows still go through the shadow store to keep it in step.
      foreach (directed_rows[i]) begin
         want = cache_lookup(directed_rows[i].op, directed_rows[i].blk);
         if (directed_rows[i].typed) begin
            want.hit    = directed_rows[i].hit;
            want.wb     = directed_rows[i].wb;
            want.wb_blk = directed_rows[i].wb_blk;
            want.fill   = directed_rows[i].fill;
            want.idx    = directed_rows[i].idx;
         end
         offer(directed_rows[i].op, directed_rows[i].blk, want);
      end

      // A few busy lines, the two end lines among them, so that random traffic keeps
      // returning to lines it has already filled.
      hot[0] = '0;
      hot[1] = '1;
      for (int i = 2; i < HOT_LINES; i++) begin
         hot[i] = IDX_W'($urandom);
      end

      // Three phases of random items: receiver idles more, then the sender, then neither.
      for (int phase = 0; phase < 3; phase++) begin
         unique case (phase)
            0: begin
               send_idle_pct = 37;
               recv_idle_pct = 51;
            end
            1: begin
               send_idle_pct = 51;
               recv_idle_pct = 37;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
            end
         endcase
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // Reads and writes are weighted above syncs and removes.
            pick = $urandom_range(99);
            if (pick < 35) begin
               op = MODE_READ;
            end else if (pick < 70) begin
               op = MODE_WRITE;
            end else if (pick < 85) begin
               op = MODE_SYNC;
            end else begin
               op = MODE_REMOVE;
            end
            if ($urandom_range(99) < 20) begin
               blk = BLOCK_W'($urandom);
            end else begin
               idx = hot[HOT_W'($urandom_range(HOT_LINES-1))];
               if ($urandom_range(9) == 0) begin
                  tg = TAG_W'($urandom);
               end else begin
                  tg = TAG_W'($urandom_range(3));
               end
               blk = {tg, idx};
            end
            want = cache_lookup(op, blk);
            offer(op, blk, want);
         end
      end
      req_tvalid <= 1'b0;

      while (pending_rsps.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire

>>> direct_mapped_writeback_cache_tags.f
design/dmwct_pkg.sv
design/dmwct_ctrl.sv
design/dmwct_dp.sv
design/direct_mapped_writeback_cache_tags.sv
tb/testbench.sv
